### rtl/core/nnlct_pkg.sv
// Shared constants and codes for the nearest-neighbor line-cross tracker.
`timescale 1ns / 1ps
`default_nettype none
package nnlct_pkg;

  localparam int MaxTracksDefault = 16;
  localparam int CoordBitsDefault = 11;

  localparam int CfgBits   = 11;
  localparam int MissBits  = 5;
  localparam int KindBits  = 3;
  localparam int CountBits = 5;

  localparam logic [CfgBits-1:0]  RadiusReset = 11'd120;
  localparam logic [MissBits-1:0] MissReset   = 5'd30;
  localparam logic [CfgBits-1:0]  TopReset    = 11'd50;
  localparam logic [CfgBits-1:0]  BottomReset = 11'd440;

  localparam logic OpDetect   = 1'b0;
  localparam logic OpEndFrame = 1'b1;

  localparam logic [KindBits-1:0] KindAck      = 3'd0;
  localparam logic [KindBits-1:0] KindExit     = 3'd1;
  localparam logic [KindBits-1:0] KindEnter    = 3'd2;
  localparam logic [KindBits-1:0] KindFrame    = 3'd3;
  localparam logic [KindBits-1:0] KindOverflow = 3'd4;

  localparam logic [1:0] RegRadius = 2'd0;
  localparam logic [1:0] RegMiss   = 2'd1;
  localparam logic [1:0] RegTop    = 2'd2;
  localparam logic [1:0] RegBottom = 2'd3;

endpackage
`default_nettype wire

### rtl/core/nnlct_isqrt.sv
// Bit-serial integer square root, one root bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module nnlct_isqrt #(
  parameter int RootBits = 12
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [2*RootBits-1:0] radicand,
  output logic                       done,
  output logic [RootBits-1:0]        root
);

  localparam int RemBits = RootBits + 3;
  localparam int CntBits = $clog2(RootBits + 1);

  logic                  busy;
  logic [CntBits-1:0]    cnt;
  logic [RemBits-1:0]    rem;
  logic [2*RootBits-1:0] dsh;
  logic [RemBits-1:0]    rem_t;
  logic [RemBits-1:0]    trial;

  assign rem_t = {rem[RemBits-3:0], dsh[2*RootBits-1 -: 2]};
  assign trial = RemBits'({root, 2'b01});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
      rem  <= '0;
      root <= '0;
      dsh  <= radicand;
    end else if (busy) begin
      if (rem_t >= trial) begin
        rem  <= rem_t - trial;
        root <= {root[RootBits-2:0], 1'b1};
      end else begin
        rem  <= rem_t;
        root <= {root[RootBits-2:0], 1'b0};
      end
      dsh <= {dsh[2*RootBits-3:0], 2'b00};
      cnt <= cnt + 1'b1;
      if (cnt == CntBits'(RootBits - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/core/nnlct_mem.sv
// Track memory: both frame tables, one write and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module nnlct_mem #(
  parameter int Width     = 40,
  parameter int AddrBits  = 5
) (
  input  wire logic                clk,
  input  wire logic                wr_en,
  input  wire logic [AddrBits-1:0] wr_addr,
  input  wire logic [Width-1:0]    wr_data,
  input  wire logic                rd_en,
  input  wire logic [AddrBits-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);

  logic [Width-1:0] mem [2**AddrBits];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

### rtl/core/nearest_neighbor_line_cross_tracker.sv
// Top level: frame-to-frame tracker with line-crossing events.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  in       | in_valid / in_stall  | opcode, center_x, center_y, box_height
//  out      | out_valid / out_stall| kind, matched, track_count, last
//  cfg      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One item at a time. A detection runs each untaken previous track through
// the shared bit-serial square root (RootBits = COORD_BITS+1) and skips
// taken ones; end of frame carries over or retires each untaken track,
// emitting overflow, exit and enter events, then a frame-done result.
// Reset clears counts, taken flags and the frame bank; tables need no clearing.
// A stalled result holds the sequencer only when another result is due.
`timescale 1ns / 1ps
`default_nettype none
module nearest_neighbor_line_cross_tracker #(
  parameter int MAX_TRACKS = nnlct_pkg::MaxTracksDefault,
  parameter int COORD_BITS = nnlct_pkg::CoordBitsDefault
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic                            opcode,
  input  wire logic [COORD_BITS-1:0]           center_x,
  input  wire logic [COORD_BITS-1:0]           center_y,
  input  wire logic [COORD_BITS-1:0]           box_height,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [nnlct_pkg::KindBits-1:0]       kind,
  output logic                                 matched,
  output logic [nnlct_pkg::CountBits-1:0]      track_count,
  output logic                                 last,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [1:0]                      cfg_index,
  input  wire logic [nnlct_pkg::CfgBits-1:0]   cfg_data
);

  localparam int CB   = COORD_BITS;
  localparam int RB   = CB + 1;
  localparam int MB   = nnlct_pkg::MissBits;
  localparam int TW   = 3 * CB + 2 + MB;
  localparam int IW   = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int CW   = $clog2(MAX_TRACKS + 1);
  localparam int CMPW = (RB > nnlct_pkg::CfgBits) ? RB : nnlct_pkg::CfgBits;
  localparam int LW   = ((CB > nnlct_pkg::CfgBits) ? CB : nnlct_pkg::CfgBits) + 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DRD   = 4'd1;
  localparam logic [3:0] S_DMUL  = 4'd2;
  localparam logic [3:0] S_DSUM  = 4'd3;
  localparam logic [3:0] S_DSQ   = 4'd4;
  localparam logic [3:0] S_DDONE = 4'd5;
  localparam logic [3:0] S_ERD   = 4'd6;
  localparam logic [3:0] S_ECHK  = 4'd7;
  localparam logic [3:0] S_EEMIT = 4'd8;
  localparam logic [3:0] S_EFIN  = 4'd9;

  logic [3:0] state;
  logic [CW-1:0] idx, prev_count, cur_count;
  logic bank;
  logic [MAX_TRACKS-1:0] taken;
  logic [CB-1:0] cx, cy, ch;
  logic found;
  logic [IW-1:0] best_idx;
  logic [RB-1:0] best_d;
  logic best_top, best_bot;
  logic pend_ovf, pend_exit, pend_enter;
  logic [2*CB-1:0] sq_x, sq_y;

  logic [nnlct_pkg::CfgBits-1:0] match_radius, top_line, bottom_line;
  logic [MB-1:0] miss_limit;

  logic          mem_we, mem_re;
  logic [IW:0]   mem_waddr, mem_raddr;
  logic [TW-1:0] mem_wdata, mem_rdata;
  logic          sq_start, sq_done;
  logic [RB-1:0] sq_root;

  logic [CB-1:0] r_x, r_y, r_h;
  logic          r_top, r_bot;
  logic [MB-1:0] r_miss, miss_inc;
  logic [CB-1:0] ax, ay;
  logic          slot_free, full, det_match, new_top, new_bot, old_exit, old_enter;
  logic          emit;

  assign {r_x, r_y, r_h, r_top, r_bot, r_miss} = mem_rdata;
  assign miss_inc = r_miss + 1'b1;
  assign ax = (cx >= r_x) ? cx - r_x : r_x - cx;
  assign ay = (cy >= r_y) ? cy - r_y : r_y - cy;
  assign slot_free = !out_valid || !out_stall;
  assign full = (cur_count >= CW'(MAX_TRACKS));
  assign det_match = found && (CMPW'(best_d) < CMPW'(match_radius));
  assign new_top = LW'(cy) < LW'(top_line) + LW'(ch >> 1);
  assign new_bot = LW'(cy) + LW'(ch >> 1) > LW'(bottom_line);
  assign old_exit = r_top && (LW'(r_y) + LW'(r_h >> 1) > LW'(bottom_line));
  assign old_enter = r_bot && (LW'(r_y) < LW'(top_line) + LW'(r_h >> 1));

  // a result register load this cycle
  assign emit = slot_free && ((state == S_DDONE) || (state == S_EFIN)
                || ((state == S_EEMIT) && (pend_ovf || pend_exit || pend_enter)));

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  assign mem_raddr = {bank, idx[IW-1:0]};
  assign mem_re    = ((state == S_DRD) || (state == S_ERD)) && (idx < prev_count)
                     && !taken[idx[IW-1:0]];
  assign mem_waddr = {~bank, cur_count[IW-1:0]};
  assign sq_start  = (state == S_DSUM);

  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = {cx, cy, ch, new_top, new_bot, MB'(0)};
    if (state == S_DDONE && slot_free && !full) begin
      mem_we = 1'b1;
      if (det_match) begin
        mem_wdata = {cx, cy, ch, best_top, best_bot, MB'(0)};
      end
    end else if (state == S_ECHK && miss_inc < miss_limit && !full) begin
      mem_we    = 1'b1;
      mem_wdata = {r_x, r_y, r_h, r_top, r_bot, miss_inc};
    end
  end

  nnlct_mem #(.Width(TW), .AddrBits(IW + 1)) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  nnlct_isqrt #(.RootBits(RB)) u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand ((2*RB)'(sq_x) + (2*RB)'(sq_y)),
    .done     (sq_done),
    .root     (sq_root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      match_radius <= nnlct_pkg::RadiusReset;
      miss_limit   <= nnlct_pkg::MissReset;
      top_line     <= nnlct_pkg::TopReset;
      bottom_line  <= nnlct_pkg::BottomReset;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        nnlct_pkg::RegRadius: match_radius <= cfg_data;
        nnlct_pkg::RegMiss:   miss_limit   <= cfg_data[MB-1:0];
        nnlct_pkg::RegTop:    top_line     <= cfg_data;
        nnlct_pkg::RegBottom: bottom_line  <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      prev_count <= '0;
      cur_count  <= '0;
      bank       <= 1'b0;
      taken      <= '0;
      out_valid  <= 1'b0;
    end else begin
      out_valid <= emit || (out_valid && out_stall);
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cx    <= center_x;
            cy    <= center_y;
            ch    <= box_height;
            idx   <= '0;
            found <= 1'b0;
            state <= (opcode == nnlct_pkg::OpEndFrame) ? S_ERD : S_DRD;
          end
        end
        S_DRD: begin
          if (idx >= prev_count) begin
            state <= S_DDONE;
          end else if (taken[idx[IW-1:0]]) begin
            idx <= idx + 1'b1;
          end else begin
            state <= S_DMUL;
          end
        end
        S_DMUL: begin
          sq_x  <= ax * ax;
          sq_y  <= ay * ay;
          state <= S_DSUM;
        end
        S_DSUM: state <= S_DSQ;
        S_DSQ: begin
          if (sq_done) begin
            if (!found || sq_root < best_d) begin
              found    <= 1'b1;
              best_d   <= sq_root;
              best_idx <= idx[IW-1:0];
              best_top <= r_top;
              best_bot <= r_bot;
            end
            idx   <= idx + 1'b1;
            state <= S_DRD;
          end
        end
        S_DDONE: begin
          if (slot_free) begin
            if (det_match) begin
              taken[best_idx] <= 1'b1;
            end
            matched     <= det_match;
            last        <= 1'b1;
            kind        <= full ? nnlct_pkg::KindOverflow : nnlct_pkg::KindAck;
            track_count <= nnlct_pkg::CountBits'(full ? cur_count : cur_count + 1'b1);
            if (!full) begin
              cur_count <= cur_count + 1'b1;
            end
            state <= S_IDLE;
          end
        end
        S_ERD: begin
          if (idx >= prev_count) begin
            state <= S_EFIN;
          end else if (taken[idx[IW-1:0]]) begin
            idx <= idx + 1'b1;
          end else begin
            state <= S_ECHK;
          end
        end
        S_ECHK: begin
          if (miss_inc < miss_limit) begin
            pend_ovf   <= full;
            pend_exit  <= 1'b0;
            pend_enter <= 1'b0;
            if (!full) begin
              cur_count <= cur_count + 1'b1;
            end
          end else begin
            pend_ovf   <= 1'b0;
            pend_exit  <= old_exit;
            pend_enter <= old_enter;
          end
          state <= S_EEMIT;
        end
        S_EEMIT: begin
          if (pend_ovf || pend_exit || pend_enter) begin
            if (slot_free) begin
              matched     <= 1'b0;
              last        <= 1'b0;
              track_count <= nnlct_pkg::CountBits'(cur_count);
              priority if (pend_ovf) begin
                kind     <= nnlct_pkg::KindOverflow;
                pend_ovf <= 1'b0;
              end else if (pend_exit) begin
                kind      <= nnlct_pkg::KindExit;
                pend_exit <= 1'b0;
              end else begin
                kind       <= nnlct_pkg::KindEnter;
                pend_enter <= 1'b0;
              end
            end
          end else begin
            idx   <= idx + 1'b1;
            state <= S_ERD;
          end
        end
        S_EFIN: begin
          if (slot_free) begin
            bank        <= ~bank;
            prev_count  <= cur_count;
            cur_count   <= '0;
            taken       <= '0;
            matched     <= 1'b0;
            last        <= 1'b1;
            kind        <= nnlct_pkg::KindFrame;
            track_count <= nnlct_pkg::CountBits'(cur_count);
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

### rtl/core/nnlct_checker.sv
// Port-level checks on the tracker's result channel.
`timescale 1ns / 1ps
`default_nettype none
module nnlct_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            out_valid,
  input wire logic                            out_stall,
  input wire logic [nnlct_pkg::KindBits-1:0]  kind,
  input wire logic                            matched,
  input wire logic                            last
);

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> kind <= nnlct_pkg::KindOverflow)
    else $error("result kind out of range");

  a_matched_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && matched |->
      (kind == nnlct_pkg::KindAck || kind == nnlct_pkg::KindOverflow))
    else $error("matched set on a non-detection result");

  a_frame_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == nnlct_pkg::KindFrame || kind == nnlct_pkg::KindAck) |-> last)
    else $error("frame done or ack not marked last");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(last))
    else $error("stalled result changed");

endmodule

bind nearest_neighbor_line_cross_tracker nnlct_checker u_nnlct_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .kind      (kind),
  .matched   (matched),
  .last      (last)
);
`default_nettype wire

### test/nearest_neighbor_line_cross_tracker_checker.sv
// Checker for the tracker: tracks the configuration, predicts results and compares them.
`timescale 1ns / 1ps
module nearest_neighbor_line_cross_tracker_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            opcode,
  input logic [10:0]                     center_x,
  input logic [10:0]                     center_y,
  input logic [10:0]                     box_height,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [nnlct_pkg::KindBits-1:0]  kind,
  input logic                            matched,
  input logic [nnlct_pkg::CountBits-1:0] track_count,
  input logic                            last,
  input logic                            cfg_valid,
  input logic                            cfg_ready,
  input logic [1:0]                      cfg_index,
  input logic [nnlct_pkg::CfgBits-1:0]   cfg_data,
  output int                             errors,
  output int                             pending
);

  typedef struct packed {
    logic [10:0] x;
    logic [10:0] y;
    logic [10:0] h;
    logic        top;
    logic        bot;
    logic [4:0]  miss;
  } track_t;

  typedef struct packed {
    logic [nnlct_pkg::KindBits-1:0]  kind;
    logic                            matched;
    logic [nnlct_pkg::CountBits-1:0] count;
    logic                            last;
  } event_t;

  logic [10:0] radius, top_ln, bot_ln;
  logic [4:0]  miss_lim;
  track_t      prev_trk [16];
  track_t      cur_trk [16];
  logic        taken [16];
  int          prev_n, cur_n;
  event_t      expected_q [$];

  assign pending = expected_q.size();

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned r;
    r = 0;
    for (int b = 31; b >= 0; b--)
      if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= v) r |= 64'd1 << b;
    return r;
  endfunction

  function automatic void push_event(logic [2:0] k, logic m, int c);
    event_t e;
    e.kind = k;
    e.matched = m;
    e.count = c[4:0];
    e.last = 1'b0;
    expected_q.insert(expected_q.size(), e);
  endfunction

  function automatic bit add_track(track_t t);
    if (cur_n >= 16) return 1'b0;
    cur_trk[cur_n] = t;
    cur_n++;
    return 1'b1;
  endfunction

  task automatic predict_item(logic op, logic [10:0] x, logic [10:0] y, logic [10:0] h);
    bit              found, hit;
    int              best, topy, boty;
    longint unsigned bestd, d;
    longint          dx, dy;
    track_t          t;
    event_t          e;
    found = 1'b0;
    best = 0;
    bestd = 0;
    if (op == nnlct_pkg::OpDetect) begin
      for (int i = 0; i < prev_n; i++) begin
        if (taken[i]) continue;
        dx = longint'(prev_trk[i].x) - longint'(x);
        dy = longint'(prev_trk[i].y) - longint'(y);
        d = floor_root(dx * dx + dy * dy);
        if (!found || d < bestd) begin
          found = 1'b1;
          bestd = d;
          best = i;
        end
      end
      hit = found && bestd < radius;
      if (hit) begin
        taken[best] = 1'b1;
        t = prev_trk[best];
      end else begin
        topy = int'(y) - int'(h / 2);
        boty = int'(y) + int'(h / 2);
        t.top = topy < int'(top_ln);
        t.bot = boty > int'(bot_ln);
      end
      t.x = x;
      t.y = y;
      t.h = h;
      t.miss = '0;
      if (add_track(t)) push_event(nnlct_pkg::KindAck, hit, cur_n);
      else push_event(nnlct_pkg::KindOverflow, hit, cur_n);
    end else begin
      for (int i = 0; i < prev_n; i++) begin
        if (taken[i]) continue;
        t = prev_trk[i];
        t.miss = t.miss + 5'd1;
        if (t.miss < miss_lim) begin
          if (!add_track(t)) push_event(nnlct_pkg::KindOverflow, 1'b0, cur_n);
        end else begin
          topy = int'(t.y) - int'(t.h / 2);
          boty = int'(t.y) + int'(t.h / 2);
          if (t.top && boty > int'(bot_ln)) push_event(nnlct_pkg::KindExit, 1'b0, cur_n);
          if (t.bot && topy < int'(top_ln)) push_event(nnlct_pkg::KindEnter, 1'b0, cur_n);
        end
      end
      prev_trk = cur_trk;
      prev_n = cur_n;
      foreach (taken[i]) taken[i] = 1'b0;
      cur_n = 0;
      push_event(nnlct_pkg::KindFrame, 1'b0, prev_n);
    end
    e = expected_q[expected_q.size() - 1];
    e.last = 1'b1;
    expected_q[expected_q.size() - 1] = e;
  endtask

  always @(posedge clk) begin
    event_t e;
    if (rst) begin
      radius <= nnlct_pkg::RadiusReset;
      miss_lim <= nnlct_pkg::MissReset;
      top_ln <= nnlct_pkg::TopReset;
      bot_ln <= nnlct_pkg::BottomReset;
      prev_n = 0;
      cur_n = 0;
      foreach (taken[i]) taken[i] = 1'b0;
      expected_q.delete();
      errors <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          nnlct_pkg::RegRadius: radius <= cfg_data;
          nnlct_pkg::RegMiss:   miss_lim <= cfg_data[4:0];
          nnlct_pkg::RegTop:    top_ln <= cfg_data;
          nnlct_pkg::RegBottom: bot_ln <= cfg_data;
        endcase
      end
      if (in_valid && !in_stall) predict_item(opcode, center_x, center_y, box_height);
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result kind=%0d matched=%0d count=%0d last=%0d",
                   $time, kind, matched, track_count, last);
          errors <= errors + 1;
        end else begin
          e = expected_q.pop_front();
          if (e != {kind, matched, track_count, last}) begin
            $display("%0t: expected kind=%0d matched=%0d count=%0d last=%0d, got %0d %0d %0d %0d",
                     $time, e.kind, e.matched, e.count, e.last,
                     kind, matched, track_count, last);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

### test/nearest_neighbor_line_cross_tracker_test.sv
// Testbench top: drives detections, frame ends and register writes into the tracker.
`timescale 1ns / 1ps
module nearest_neighbor_line_cross_tracker_test;

  logic                            clk = 0;
  logic                            rst = 1;
  logic                            in_valid = 0, in_stall;
  logic                            opcode = 0;
  logic [10:0]                     center_x = 0, center_y = 0, box_height = 0;
  logic                            out_valid, out_stall = 0;
  logic [nnlct_pkg::KindBits-1:0]  kind;
  logic                            matched;
  logic [nnlct_pkg::CountBits-1:0] track_count;
  logic                            last;
  logic                            cfg_valid = 0, cfg_ready;
  logic [1:0]                      cfg_index = 0;
  logic [nnlct_pkg::CfgBits-1:0]   cfg_data = 0;
  int                              errors, pending;
  bit                              calm_in = 0, calm_out = 0, hold_out = 0;

  nearest_neighbor_line_cross_tracker dut (.*);
  nearest_neighbor_line_cross_tracker_checker check (.*);

  always #5 clk = ~clk;

  // receiver: random stalls, a calm stretch, and one long hold-off
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else if (hold_out) out_stall <= 1'b1;
    else out_stall <= !calm_out && ($urandom_range(99) < 20);
  end

  // the block raises in_stall after taking an item
  task automatic send(logic op, int x, int y, int h);
    while (!calm_in && $urandom_range(99) < 20) @(posedge clk);
    in_valid <= 1'b1;
    opcode <= op;
    center_x <= 11'(x);
    center_y <= 11'(y);
    box_height <= 11'(h);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= nnlct_pkg::CfgBits'(val);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  // random frame around a few moving objects, with the odd wild detection
  task automatic random_frame(int dets);
    for (int i = 0; i < dets; i++) begin
      if ($urandom_range(9) == 0)
        send(nnlct_pkg::OpDetect, $urandom_range(2047), $urandom_range(2047),
             $urandom_range(2047));
      else
        send(nnlct_pkg::OpDetect, 200 * (i % 5) + $urandom_range(40),
             30 * (i % 4) + $urandom_range(500), $urandom_range(300));
    end
    send(nnlct_pkg::OpEndFrame, $urandom_range(2047), $urandom_range(2047),
         $urandom_range(2047));
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // empty frame, extremes, a top starter moving down, a bottom starter moving up
    send(nnlct_pkg::OpEndFrame, 0, 0, 0);
    send(nnlct_pkg::OpDetect, 0, 0, 0);
    send(nnlct_pkg::OpDetect, 2047, 2047, 2047);
    send(nnlct_pkg::OpDetect, 300, 20, 40);
    send(nnlct_pkg::OpDetect, 900, 470, 60);
    send(nnlct_pkg::OpEndFrame, 2047, 2047, 2047);
    send(nnlct_pkg::OpDetect, 310, 470, 40);
    send(nnlct_pkg::OpDetect, 905, 20, 60);
    send(nnlct_pkg::OpEndFrame, 0, 0, 0);
    drain();
    write_reg(nnlct_pkg::RegMiss, 1);
    write_reg(nnlct_pkg::RegRadius, 2047);
    write_reg(nnlct_pkg::RegTop, 0);
    write_reg(nnlct_pkg::RegBottom, 2047);
    send(nnlct_pkg::OpEndFrame, 0, 0, 0);
    // overflow the table of detections, then survivors
    for (int i = 0; i < 18; i++) send(nnlct_pkg::OpDetect, 100 * i, 100 * i, 10);
    send(nnlct_pkg::OpEndFrame, 0, 0, 0);
    drain();
    write_reg(nnlct_pkg::RegMiss, 31);
    write_reg(nnlct_pkg::RegRadius, 1);
    write_reg(nnlct_pkg::RegTop, 2047);
    write_reg(nnlct_pkg::RegBottom, 0);
    for (int i = 0; i < 17; i++) send(nnlct_pkg::OpDetect, 50 * i, 7, 0);
    send(nnlct_pkg::OpEndFrame, 0, 0, 0);
    drain();
    write_reg(nnlct_pkg::RegMiss, 0);
    send(nnlct_pkg::OpEndFrame, 0, 0, 0);
    drain();
    write_reg(nnlct_pkg::RegRadius, 120);
    write_reg(nnlct_pkg::RegMiss, 3);
    write_reg(nnlct_pkg::RegTop, 50);
    write_reg(nnlct_pkg::RegBottom, 440);
    // long receiver hold-off while items keep coming
    fork
      begin
        hold_out = 1;
        repeat (3000) @(posedge clk);
        hold_out = 0;
      end
      random_frame(6);
    join
    for (int f = 0; f < 16; f++) random_frame($urandom_range(8));
    calm_in = 1;
    calm_out = 1;
    for (int f = 0; f < 5; f++) random_frame($urandom_range(6));
    calm_in = 0;
    calm_out = 0;
    drain();
    write_reg(nnlct_pkg::RegRadius, $urandom_range(1, 2047));
    write_reg(nnlct_pkg::RegMiss, $urandom_range(1, 31));
    write_reg(nnlct_pkg::RegTop, $urandom_range(2047));
    write_reg(nnlct_pkg::RegBottom, $urandom_range(2047));
    for (int f = 0; f < 14; f++) random_frame($urandom_range(8));
    drain();
    if (errors == 0 && pending == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #20ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
